// ===== hdl/atpr_pkg.sv =====
// ----------------------------------------------------------------------------
// atpr_pkg
// Shared widths, constants, codes and the arctangent table for the
// accelerometer tilt block.
// ----------------------------------------------------------------------------
package atpr_pkg;

   localparam int ANGLE_FRAC_BITS = 8;
   localparam int CORDIC_STEPS    = 16;
   localparam int TABLE_LEN       = 24;
   localparam int TABLE_FRAC      = 16;
   localparam int MAG_SH          = 8;
   localparam int RIGHT_ANGLE     = 90;

   localparam int ID_W    = 8;
   localparam int AXIS_W  = 16;
   localparam int ANGLE_W = 16;
   localparam int SQ_W    = 32;
   localparam int RAD_W   = 48;
   localparam int ROOT_W  = 24;
   localparam int REM_W   = ROOT_W + 1;
   localparam int CW      = 27;
   localparam int ZW      = 25;
   localparam int STEP_W  = 5;

   localparam logic [ID_W-1:0] EXPECTED_ID_RESET = 8'h69;

   localparam int ROUND_SH = TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam int N_CORDIC = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   localparam logic [STEP_W-1:0] SQRT_LAST   = STEP_W'(ROOT_W - 1);
   localparam logic [STEP_W-1:0] CORDIC_LAST = STEP_W'(N_CORDIC - 1);

   localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1 << (ROUND_SH - 1));
   localparam logic signed [ZW-1:0] ANGLE_LIM  = ZW'(RIGHT_ANGLE << ANGLE_FRAC_BITS);
   localparam logic signed [ZW-1:0] ANGLE_MAX  = ZW'((1 << (ANGLE_W - 1)) - 1);
   localparam logic signed [ZW-1:0] ANGLE_MIN  = ~ANGLE_MAX;
   localparam logic signed [ZW-1:0] ANGLE_HI   = (ANGLE_LIM > ANGLE_MAX) ? ANGLE_MAX
                                                                        : ANGLE_LIM;
   localparam logic signed [ZW-1:0] ANGLE_LO   = (ANGLE_LIM > ANGLE_MAX) ? ANGLE_MIN
                                                                        : -ANGLE_LIM;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_SQ_A,
      OP_SQ_B,
      OP_SQRT,
      OP_CLOAD,
      OP_CORDIC,
      OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_SQRT,
      ST_CLOAD,
      ST_CORDIC,
      ST_FINISH,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [STEP_W-1:0]  step;
      logic               sel;
      logic               load_rsp;
      logic               ready;
   } ctl_type;

   // atan(2^-i) in degrees, 16 fraction bits
   function automatic logic signed [ZW-1:0] atan_deg(input logic [STEP_W-1:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:    v = ZW'(2949120);
         5'd1:    v = ZW'(1740967);
         5'd2:    v = ZW'(919879);
         5'd3:    v = ZW'(466945);
         5'd4:    v = ZW'(234379);
         5'd5:    v = ZW'(117304);
         5'd6:    v = ZW'(58666);
         5'd7:    v = ZW'(29335);
         5'd8:    v = ZW'(14668);
         5'd9:    v = ZW'(7334);
         5'd10:   v = ZW'(3667);
         5'd11:   v = ZW'(1833);
         5'd12:   v = ZW'(917);
         5'd13:   v = ZW'(458);
         5'd14:   v = ZW'(229);
         5'd15:   v = ZW'(115);
         5'd16:   v = ZW'(57);
         5'd17:   v = ZW'(29);
         5'd18:   v = ZW'(14);
         5'd19:   v = ZW'(7);
         5'd20:   v = ZW'(4);
         5'd21:   v = ZW'(2);
         5'd22:   v = ZW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/atpr_if.sv =====
// ----------------------------------------------------------------------------
// atpr_if
// Valid/ready channels of the tilt block: sensor frame in, angles out.
// ----------------------------------------------------------------------------
interface atpr_req_if;
   import atpr_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ID_W-1:0]          sensor_id;
   logic signed [AXIS_W-1:0] accel_x;
   logic signed [AXIS_W-1:0] accel_y;
   logic signed [AXIS_W-1:0] accel_z;

   modport source (output valid, output sensor_id, output accel_x, output accel_y,
                   output accel_z, input ready);
   modport sink   (input valid, input sensor_id, input accel_x, input accel_y,
                   input accel_z, output ready);
endinterface

interface atpr_rsp_if;
   import atpr_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      id_error;
   logic signed [ANGLE_W-1:0] pitch;
   logic signed [ANGLE_W-1:0] roll;

   modport source (output valid, output id_error, output pitch, output roll,
                   input ready);
   modport sink   (input valid, input id_error, input pitch, input roll,
                   output ready);
endinterface

// ===== hdl/atpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// atpr_ctrl
// Sequencer: on an ID match, squares, square root digits, CORDIC steps and finish,
// once for pitch and once for roll, then hands the beat to the output register.
// ----------------------------------------------------------------------------
module atpr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              id_match,
   input  logic              rsp_free,
   output atpr_pkg::ctl_type ctl
);
   import atpr_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      sel_in       = sel_ff;
      ctl.op       = OP_NONE;
      ctl.step     = step_ff;
      ctl.sel      = sel_ff;
      ctl.load_rsp = 1'b0;
      ctl.ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            ctl.ready = 1'b1;
            if (start) begin
               sel_in   = 1'b0;
               state_in = id_match ? ST_SQ_A : ST_DONE;
            end
         end
         ST_SQ_A: begin
            ctl.op   = OP_SQ_A;
            state_in = ST_SQ_B;
         end
         ST_SQ_B: begin
            ctl.op   = OP_SQ_B;
            step_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            ctl.op  = OP_SQRT;
            step_in = step_ff + 1'b1;
            if (step_ff == SQRT_LAST) begin
               state_in = ST_CLOAD;
            end
         end
         ST_CLOAD: begin
            ctl.op   = OP_CLOAD;
            step_in  = '0;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            ctl.op  = OP_CORDIC;
            step_in = step_ff + 1'b1;
            if (step_ff == CORDIC_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            ctl.op = OP_FINISH;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = ST_SQ_A;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== hdl/atpr_dp.sv =====
// ----------------------------------------------------------------------------
// atpr_dp
// Shared arithmetic unit: one squaring multiplier, a radix-2 square root
// digit stage and one CORDIC vectoring stage, plus the held angles.
// ----------------------------------------------------------------------------
module atpr_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  atpr_pkg::ctl_type                 ctl,
   input  logic signed [atpr_pkg::AXIS_W-1:0] x,
   input  logic signed [atpr_pkg::AXIS_W-1:0] y,
   input  logic signed [atpr_pkg::AXIS_W-1:0] z,
   output logic signed [atpr_pkg::ANGLE_W-1:0] pitch,
   output logic signed [atpr_pkg::ANGLE_W-1:0] roll
);
   import atpr_pkg::*;

   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic [RAD_W-1:0]          rad_ff, rad_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic signed [CW-1:0]      cx_ff, cx_in;
   logic signed [CW-1:0]      cy_ff, cy_in;
   logic signed [ZW-1:0]      cz_ff, cz_in;
   logic signed [ANGLE_W-1:0] pitch_ff, pitch_in;
   logic signed [ANGLE_W-1:0] roll_ff, roll_in;

   logic signed [AXIS_W-1:0]   n_ax, a_ax, m_op;
   logic                       neg;
   logic [AXIS_W-1:0]          mag;
   logic signed [2*AXIS_W-1:0] prod;
   logic [SQ_W-1:0]            sum;
   logic [REM_W+1:0]           rem_cat, trial, rem_sub;
   logic signed [CW-1:0]       sx, sy;
   logic signed [ZW-1:0]       tval, rnd, clip, sgn, sat;

   assign n_ax = ctl.sel ? y : x;
   assign a_ax = ctl.sel ? x : y;
   assign neg  = n_ax[AXIS_W-1];
   assign mag  = neg ? (~n_ax + 1'b1) : n_ax;
   assign m_op = (ctl.op == OP_SQ_A) ? a_ax : z;
   assign prod = m_op * m_op;
   assign sum  = sq_ff + SQ_W'(prod);

   assign rem_cat = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign rem_sub = rem_cat - trial;

   assign sx   = cx_ff >>> ctl.step;
   assign sy   = cy_ff >>> ctl.step;
   assign tval = atan_deg(ctl.step);

   // round to output fraction, clamp to 0..90 deg, apply sign, saturate
   assign rnd  = (cz_ff + ROUND_HALF) >>> ROUND_SH;
   assign clip = rnd[ZW-1] ? '0 : ((rnd > ANGLE_LIM) ? ANGLE_LIM : rnd);
   assign sgn  = neg ? -clip : clip;
   assign sat  = (sgn > ANGLE_MAX) ? ANGLE_MAX : ((sgn < ANGLE_MIN) ? ANGLE_MIN : sgn);

   always_comb begin
      sq_in    = sq_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      pitch_in = pitch_ff;
      roll_in  = roll_ff;
      case (ctl.op)
         OP_SQ_A: sq_in = SQ_W'(prod);
         OP_SQ_B: begin
            rad_in  = {sum, {(RAD_W-SQ_W){1'b0}}};
            rem_in  = '0;
            root_in = '0;
         end
         OP_SQRT: begin
            rad_in = rad_ff << 2;
            if (rem_cat >= trial) begin
               rem_in  = rem_sub[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_cat[REM_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         OP_CLOAD: begin
            cx_in = {{(CW-ROOT_W){1'b0}}, root_ff};
            cy_in = {{(CW-AXIS_W-MAG_SH){1'b0}}, mag, {MAG_SH{1'b0}}};
            cz_in = '0;
         end
         OP_CORDIC: begin
            if (cy_ff > 0) begin
               cx_in = cx_ff + sy;
               cy_in = cy_ff - sx;
               cz_in = cz_ff + tval;
            end else if (cy_ff < 0) begin
               cx_in = cx_ff - sy;
               cy_in = cy_ff + sx;
               cz_in = cz_ff - tval;
            end
         end
         OP_FINISH: begin
            if (ctl.sel) begin
               roll_in = sat[ANGLE_W-1:0];
            end else begin
               pitch_in = sat[ANGLE_W-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      sq_ff   <= sq_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= '0;
         roll_ff  <= '0;
      end else begin
         pitch_ff <= pitch_in;
         roll_ff  <= roll_in;
      end
   end

   assign pitch = pitch_ff;
   assign roll  = roll_ff;

endmodule

// ===== hdl/accel_tilt_pitch_roll_top.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll_top
// Pitch and roll in signed Q8.8 degrees from one accelerometer frame, with
// identity check against a programmable byte.
//
//   port      dir   kind       carries
//   req_chan  in    valid/rdy  sensor_id, accel_x, accel_y, accel_z
//   rsp_chan  out   valid/rdy  id_error, pitch, roll
//   csr_*     in    write-only expected_id
//
// a matching frame runs the accept, then per angle squares SQ_A and SQ_B, 24
// square root digits, one load, 16 CORDIC steps and one finish on the one
// shared unit, then a hand-off when the output register is free; mismatches go
// to it directly; one frame in flight, req ready only while the sequencer is idle
// the result sits in an output register, so the next frame is taken while it
// waits; a stalled result blocks only the following frame's hand-off
// reset clears control, the held angles and restores expected_id to 0x69
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll_top (
   input  logic                          clock,
   input  logic                          reset,
   atpr_req_if.sink                      req_chan,
   atpr_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [atpr_pkg::ID_W-1:0]     csr_wr_data
);
   import atpr_pkg::*;

   logic [ID_W-1:0]           exp_id_ff;
   logic signed [AXIS_W-1:0]  x_ff, y_ff, z_ff;
   logic                      err_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_err_ff;
   logic signed [ANGLE_W-1:0] rsp_pitch_ff, rsp_roll_ff;

   ctl_type                   ctl;
   logic                      start, id_match, rsp_free;
   logic signed [ANGLE_W-1:0] pitch, roll;

   assign start    = req_chan.valid && ctl.ready;
   assign id_match = (req_chan.sensor_id == exp_id_ff);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   atpr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .id_match (id_match),
      .rsp_free (rsp_free),
      .ctl      (ctl)
   );

   atpr_dp u_dp (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .x     (x_ff),
      .y     (y_ff),
      .z     (z_ff),
      .pitch (pitch),
      .roll  (roll)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_id_ff <= EXPECTED_ID_RESET;
      end else if (csr_wr_en) begin
         exp_id_ff <= csr_wr_data;
      end
   end

   // frame capture
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= req_chan.accel_x;
         y_ff   <= req_chan.accel_y;
         z_ff   <= req_chan.accel_z;
         err_ff <= !id_match;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         rsp_err_ff   <= err_ff;
         rsp_pitch_ff <= pitch;
         rsp_roll_ff  <= roll;
      end
   end

   assign req_chan.ready    = ctl.ready;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.id_error = rsp_err_ff;
   assign rsp_chan.pitch    = rsp_pitch_ff;
   assign rsp_chan.roll     = rsp_roll_ff;

endmodule

// ===== hdl/atpr_checker.sv =====
// ----------------------------------------------------------------------------
// atpr_checker
// Port-level checks on the tilt block, bound to the top level.
// ----------------------------------------------------------------------------
module atpr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_id_error,
   input logic signed [atpr_pkg::ANGLE_W-1:0] rsp_pitch,
   input logic signed [atpr_pkg::ANGLE_W-1:0] rsp_roll
);
   import atpr_pkg::*;

   logic signed [ZW-1:0] pitch_ext, roll_ext;

   assign pitch_ext = ZW'(rsp_pitch);
   assign roll_ext  = ZW'(rsp_roll);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_id_error)
                                  && $stable(rsp_pitch) && $stable(rsp_roll))
      else $error("rsp beat changed while stalled");

   // one frame in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req ready right after a frame was taken");

   // angles stay within the clamp range
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pitch_ext <= ANGLE_HI && pitch_ext >= ANGLE_LO
                    && roll_ext <= ANGLE_HI && roll_ext >= ANGLE_LO)
      else $error("angle outside clamp range");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind accel_tilt_pitch_roll_top atpr_checker u_atpr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_id_error (rsp_chan.id_error),
   .rsp_pitch    (rsp_chan.pitch),
   .rsp_roll     (rsp_chan.roll)
);
